// File: rtl/core/fwgb_pkg.sv
package fwgb_pkg;

  localparam int ATLAS_WORDS    = 65536;
  localparam int ATLAS_AW       = $clog2(ATLAS_WORDS);
  localparam int MAX_GLYPH_SIDE = 8;
  localparam int OFF_W          = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_COLOUR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH   = 3'd6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
    logic [12:0] atlas_width;
    logic [15:0] transparent_colour;
    logic        mono_enable;
    logic [15:0] mono_colour;
    logic [11:0] dest_width;
  } cfg_t;

  // one queued command: a load, or a draw already clipped and located
  typedef struct packed {
    logic             op;
    logic [15:0]      addr;
    logic [15:0]      data;
    logic [10:0]      col0;
    logic [OFF_W-1:0] ncols;
    logic [OFF_W-1:0] nrows;
    logic [21:0]      base;
  } cmd_t;

  function automatic logic [3:0] clamp_side(logic [3:0] s);
    return (s > 4'(MAX_GLYPH_SIDE)) ? 4'(MAX_GLYPH_SIDE) : s;
  endfunction

  function automatic logic [12:0] eff_atlas_width(logic [12:0] w);
    return (w == 13'd0) ? 13'd1 : w;
  endfunction

endpackage

// File: rtl/core/fwgb_queue.sv
module fwgb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fwgb_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output fwgb_pkg::cmd_t pop_data,
  output logic           empty
);

  fwgb_pkg::cmd_t                mem_r [fwgb_pkg::QUEUE_DEPTH];
  logic [fwgb_pkg::QPTR_W-1:0]   wptr_r;
  logic [fwgb_pkg::QPTR_W-1:0]   rptr_r;
  logic [fwgb_pkg::QPTR_W:0]     count_r;

  assign full     = (count_r == (fwgb_pkg::QPTR_W+1)'(fwgb_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/fwgb_front.sv
module fwgb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  fwgb_pkg::cfg_t     cfg,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [15:0]        in_atlas_addr,
  input  logic [15:0]        in_atlas_data,
  input  logic [7:0]         in_char_code,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [10:0]        in_clip_left,
  input  logic [10:0]        in_clip_top,
  input  logic [10:0]        in_clip_right,
  input  logic [10:0]        in_clip_bottom,
  input  logic               q_full,
  output logic               q_push,
  output fwgb_pkg::cmd_t     q_data
);

  localparam int DIVD_W = 12;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_MUL1 = 5'b00100,
    F_MUL2 = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [3:0]                 gw_r, gh_r;
  logic [12:0]                aw_r;
  logic signed [15:0]         x_r, y_r;
  logic [10:0]                cl_r, ct_r, cr_r, cb_r;
  logic [12:0]                rem_r;
  logic [DIVD_W-1:0]          quo_r;
  logic [3:0]                 cnt_r;
  logic [10:0]                col0_r, sy_r;
  logic [fwgb_pkg::OFF_W-1:0] u0_r, v0_r, ncols_r, nrows_r;
  logic                       nonempty_r;
  logic [15:0]                gb_r, vaw_r, src0_r;
  logic [21:0]                base_r;

  logic [3:0]         gw_in, gh_in;
  logic               accept;
  logic [13:0]        rem_sh;
  logic               ge;
  logic signed [17:0] xs, xe, ys, ye, sx, ex, sy, ey;
  logic signed [17:0] cl18, ct18, cr18, cb18;

  assign gw_in  = fwgb_pkg::clamp_side(cfg.glyph_width);
  assign gh_in  = fwgb_pkg::clamp_side(cfg.glyph_height);
  assign busy   = (state_r != F_IDLE) || q_full;
  assign accept = start && !busy;

  // restoring divide step for start / atlas_width
  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, aw_r});

  // clip box against the placed glyph
  always_comb begin
    xs   = 18'(x_r);
    ys   = 18'(y_r);
    xe   = xs + signed'({14'd0, gw_r}) - 18'sd1;
    ye   = ys + signed'({14'd0, gh_r}) - 18'sd1;
    cl18 = signed'({7'd0, cl_r});
    ct18 = signed'({7'd0, ct_r});
    cr18 = signed'({7'd0, cr_r});
    cb18 = signed'({7'd0, cb_r});
    sx   = (xs > cl18) ? xs : cl18;
    ex   = (xe < cr18) ? xe : cr18;
    sy   = (ys > ct18) ? ys : ct18;
    ey   = (ye < cb18) ? ye : cb18;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept && (in_op == fwgb_pkg::OP_DRAW) && (gw_in != 4'd0) && (gh_in != 4'd0)) begin
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (cnt_r == 4'd0) begin
          state_nxt = F_MUL1;
        end
      end
      F_MUL1: state_nxt = nonempty_r ? F_MUL2 : F_IDLE;
      F_MUL2: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        gw_r  <= gw_in;
        gh_r  <= gh_in;
        aw_r  <= fwgb_pkg::eff_atlas_width(cfg.atlas_width);
        x_r   <= in_pos_x;
        y_r   <= in_pos_y;
        cl_r  <= in_clip_left;
        ct_r  <= in_clip_top;
        cr_r  <= in_clip_right;
        cb_r  <= in_clip_bottom;
        rem_r <= '0;
        quo_r <= DIVD_W'(in_char_code) * DIVD_W'(gw_in);
        cnt_r <= 4'(DIVD_W - 1);
      end
      F_DIV: begin
        rem_r      <= ge ? 13'(rem_sh - {1'b0, aw_r}) : rem_sh[12:0];
        quo_r      <= {quo_r[DIVD_W-2:0], ge};
        cnt_r      <= cnt_r - 1'b1;
        nonempty_r <= (sx <= ex) && (sy <= ey);
        col0_r     <= sx[10:0];
        sy_r       <= sy[10:0];
        u0_r       <= fwgb_pkg::OFF_W'(sx - xs);
        v0_r       <= fwgb_pkg::OFF_W'(sy - ys);
        ncols_r    <= fwgb_pkg::OFF_W'(ex - sx);
        nrows_r    <= fwgb_pkg::OFF_W'(ey - sy);
      end
      F_MUL1: begin
        gb_r   <= 16'(gh_r) * 16'(quo_r);
        vaw_r  <= 16'(v0_r) * 16'(aw_r);
        base_r <= 22'(sy_r) * 22'(cfg.dest_width);
      end
      F_MUL2: begin
        // origin plus the first clipped pixel, all modulo 2^16
        src0_r <= 16'(rem_r) + 16'(gb_r * 16'(aw_r)) + vaw_r + 16'(u0_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    if (state_r == F_PUSH) begin
      q_push       = !q_full;
      q_data.op    = fwgb_pkg::OP_DRAW;
      q_data.addr  = src0_r;
      q_data.col0  = col0_r;
      q_data.ncols = ncols_r;
      q_data.nrows = nrows_r;
      q_data.base  = base_r;
    end else if (accept && (in_op == fwgb_pkg::OP_LOAD)) begin
      q_push      = 1'b1;
      q_data.op   = fwgb_pkg::OP_LOAD;
      q_data.addr = in_atlas_addr;
      q_data.data = in_atlas_data;
    end
  end

endmodule

// File: rtl/core/fwgb_back.sv
module fwgb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fwgb_pkg::cfg_t cfg,
  input  logic           q_empty,
  output logic           q_pop,
  input  fwgb_pkg::cmd_t q_data,
  output logic           out_valid,
  output logic [21:0]    out_dest_addr,
  output logic [15:0]    out_pixel_colour,
  output logic           out_last
);

  logic [15:0] atlas_r [fwgb_pkg::ATLAS_WORDS];
  logic [15:0] rdata_r;

  logic                       walk_r;
  logic [15:0]                src_r, srow_r;
  logic [fwgb_pkg::OFF_W-1:0] ccnt_r, rcnt_r, ncols_r, nrows_r;
  logic [21:0]                drow_r, daddr_r;

  logic        p1_valid_r, p1_end_r;
  logic [21:0] p1_addr_r;

  logic        pend_valid_r, pend_valid_nxt;
  logic        pend_final_r, pend_final_nxt;
  logic [21:0] pend_addr_r, pend_addr_nxt;
  logic [15:0] pend_colour_r, pend_colour_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [21:0] out_addr_r, out_addr_nxt;
  logic [15:0] out_colour_r, out_colour_nxt;
  logic        out_last_r, out_last_nxt;

  logic        atlas_we;
  logic        last_pix;
  logic [15:0] srow_step;
  logic [21:0] drow_step;
  logic [15:0] colour;
  logic        opaque;

  // next command waits until the previous draw has drained
  assign q_pop     = !q_empty && !walk_r && !p1_valid_r && !pend_final_r;
  assign atlas_we  = q_pop && (q_data.op == fwgb_pkg::OP_LOAD);
  assign last_pix  = (ccnt_r == ncols_r) && (rcnt_r == nrows_r);
  assign srow_step = srow_r + 16'(fwgb_pkg::eff_atlas_width(cfg.atlas_width));
  assign drow_step = drow_r + 22'(cfg.dest_width);

  always_ff @(posedge clk) begin
    if (atlas_we) begin
      atlas_r[q_data.addr[fwgb_pkg::ATLAS_AW-1:0]] <= q_data.data;
    end
    rdata_r <= atlas_r[src_r[fwgb_pkg::ATLAS_AW-1:0]];
  end

  // rectangle walker, one source read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r     <= 1'b0;
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= walk_r;
      if (q_pop && (q_data.op == fwgb_pkg::OP_DRAW)) begin
        walk_r <= 1'b1;
      end else if (walk_r && last_pix) begin
        walk_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_end_r  <= last_pix;
    p1_addr_r <= daddr_r;
    if (q_pop) begin
      src_r   <= q_data.addr;
      srow_r  <= q_data.addr;
      ccnt_r  <= '0;
      rcnt_r  <= '0;
      ncols_r <= q_data.ncols;
      nrows_r <= q_data.nrows;
      drow_r  <= q_data.base + 22'(q_data.col0);
      daddr_r <= q_data.base + 22'(q_data.col0);
    end else if (walk_r) begin
      if (ccnt_r == ncols_r) begin
        ccnt_r  <= '0;
        rcnt_r  <= rcnt_r + 1'b1;
        srow_r  <= srow_step;
        src_r   <= srow_step;
        drow_r  <= drow_step;
        daddr_r <= drow_step;
      end else begin
        ccnt_r  <= ccnt_r + 1'b1;
        src_r   <= src_r + 16'd1;
        daddr_r <= daddr_r + 22'd1;
      end
    end
  end

  always_comb begin
    if (cfg.mono_enable) begin
      colour = (rdata_r != cfg.transparent_colour) ? cfg.mono_colour : cfg.transparent_colour;
    end else begin
      colour = rdata_r;
    end
    opaque = (colour != cfg.transparent_colour);
  end

  // one write held back so the final one can carry last
  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_final_nxt  = pend_final_r;
    pend_addr_nxt   = pend_addr_r;
    pend_colour_nxt = pend_colour_r;
    out_valid_nxt   = 1'b0;
    out_addr_nxt    = pend_addr_r;
    out_colour_nxt  = pend_colour_r;
    out_last_nxt    = 1'b0;
    if (pend_final_r) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
      pend_final_nxt = 1'b0;
    end else if (p1_valid_r) begin
      if (opaque) begin
        if (pend_valid_r) begin
          out_valid_nxt   = 1'b1;
          pend_addr_nxt   = p1_addr_r;
          pend_colour_nxt = colour;
          pend_final_nxt  = p1_end_r;
        end else if (p1_end_r) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_addr_nxt   = p1_addr_r;
          out_colour_nxt = colour;
        end else begin
          pend_valid_nxt  = 1'b1;
          pend_addr_nxt   = p1_addr_r;
          pend_colour_nxt = colour;
        end
      end else if (p1_end_r && pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_final_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_final_r <= pend_final_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r   <= pend_addr_nxt;
    pend_colour_r <= pend_colour_nxt;
    out_addr_r    <= out_addr_nxt;
    out_colour_r  <= out_colour_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_dest_addr    = out_addr_r;
  assign out_pixel_colour = out_colour_r;
  assign out_last         = out_last_r;

endmodule

// File: rtl/core/fixed_width_glyph_blitter_top.sv
// load beat: queued, then written to the atlas when popped; one load per cycle unless busy
// draw beat: front busy for a 12-step origin divide, two multiply stages and the queue push
// draw output: after the pop, each pixel passes src_r, the atlas read, the held-back write
// and the output register; up to one write per cycle, set by the single atlas read port
// results are strobed for one cycle on out_valid; the receiver cannot stall
// sync reset clears control registers and presets config; atlas is undefined until loaded
module fixed_width_glyph_blitter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [15:0]                       in_atlas_addr,
  input  logic [15:0]                       in_atlas_data,
  input  logic [7:0]                        in_char_code,
  input  logic signed [15:0]                in_pos_x,
  input  logic signed [15:0]                in_pos_y,
  input  logic [10:0]                       in_clip_left,
  input  logic [10:0]                       in_clip_top,
  input  logic [10:0]                       in_clip_right,
  input  logic [10:0]                       in_clip_bottom,
  input  logic                              cfg_we,
  input  logic [fwgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwgb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  output logic [21:0]                       out_dest_addr,
  output logic [15:0]                       out_pixel_colour,
  output logic                              out_last
);

  fwgb_pkg::cfg_t cfg_r;
  fwgb_pkg::cmd_t push_data, pop_data;
  logic           q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width        <= 4'd8;
      cfg_r.glyph_height       <= 4'd8;
      cfg_r.atlas_width        <= 13'd256;
      cfg_r.transparent_colour <= 16'd0;
      cfg_r.mono_enable        <= 1'b0;
      cfg_r.mono_colour        <= 16'hFFFF;
      cfg_r.dest_width         <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        fwgb_pkg::REG_GLYPH_WIDTH:  cfg_r.glyph_width        <= cfg_wdata[3:0];
        fwgb_pkg::REG_GLYPH_HEIGHT: cfg_r.glyph_height       <= cfg_wdata[3:0];
        fwgb_pkg::REG_ATLAS_WIDTH:  cfg_r.atlas_width        <= cfg_wdata[12:0];
        fwgb_pkg::REG_TRANSPARENT:  cfg_r.transparent_colour <= cfg_wdata;
        fwgb_pkg::REG_MONO_ENABLE:  cfg_r.mono_enable        <= cfg_wdata[0];
        fwgb_pkg::REG_MONO_COLOUR:  cfg_r.mono_colour        <= cfg_wdata;
        fwgb_pkg::REG_DEST_WIDTH:   cfg_r.dest_width         <= cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  fwgb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_atlas_addr  (in_atlas_addr),
    .in_atlas_data  (in_atlas_data),
    .in_char_code   (in_char_code),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_clip_left   (in_clip_left),
    .in_clip_top    (in_clip_top),
    .in_clip_right  (in_clip_right),
    .in_clip_bottom (in_clip_bottom),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_data)
  );

  fwgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fwgb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (pop_data),
    .out_valid        (out_valid),
    .out_dest_addr    (out_dest_addr),
    .out_pixel_colour (out_pixel_colour),
    .out_last         (out_last)
  );

endmodule
